// ===== sv/modbus_rtu_response_checker_macros.svh =====
// Assertion macros shared by the checker RTL.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH
`ifndef SYNTH
`define MRRC_ASSERT_IMPL(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("mrrc implication check failed");
`define MRRC_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("mrrc next-cycle check failed");
`else
`define MRRC_ASSERT_IMPL(lbl, ant, cons)
`define MRRC_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

// ===== sv/mrrc_pkg.sv =====
`default_nettype none
package mrrc_pkg;

	localparam logic [1:0] KIND_ARM     = 2'd0;
	localparam logic [1:0] KIND_BYTE    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TIMEOUT   = 3'd1;
	localparam logic [2:0] ST_SLAVE     = 3'd2;
	localparam logic [2:0] ST_EXCEPTION = 3'd3;
	localparam logic [2:0] ST_FUNC      = 3'd4;
	localparam logic [2:0] ST_CRC       = 3'd5;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
	localparam logic [7:0] FC_WRITE_REG   = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

	localparam logic [8:0] WRITE_FRAME_LEN = 9'd8;
	localparam logic [8:0] READ_FRAME_BASE = 9'd5;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_ADDR  = 6'b000010,
		PH_FUNC  = 6'b000100,
		PH_EXC   = 6'b001000,
		PH_COUNT = 6'b010000,
		PH_BODY  = 6'b100000
	} phase_t;

endpackage
`default_nettype wire

// ===== sv/mrrc_req_if.sv =====
`default_nettype none
interface mrrc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] slave_address;
	logic [7:0] rx_byte;

	modport source (output valid, output kind, output slave_address, output rx_byte,
		input ready);
	modport sink (input valid, input kind, input slave_address, input rx_byte,
		output ready);
endinterface
`default_nettype wire

// ===== sv/mrrc_rsp_if.sv =====
`default_nettype none
interface mrrc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic [8:0] byte_position;
	logic       last;
	logic [2:0] status;
	logic [7:0] exception_code;
	logic [7:0] function_code;

	modport source (output valid, output frame_byte, output byte_position, output last,
		output status, output exception_code, output function_code, input ready);
	modport sink (input valid, input frame_byte, input byte_position, input last,
		input status, input exception_code, input function_code, output ready);
endinterface
`default_nettype wire

// ===== sv/mrrc_crc_byte.sv =====
`default_nettype none
module mrrc_crc_byte (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);
	import mrrc_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end
endmodule
`default_nettype wire

// ===== sv/modbus_rtu_response_checker.sv =====
// A request accepted is held in the input register, and its result is then registered in the result register.
// Throughput: one request per cycle while the result side takes every result; a held
// result stalls a waiting request that produces a result, and requests without one pass.
// The byte path is an input register, one CRC byte step and a result register.
// Reset is asynchronous and active low; it disarms the checker and empties both registers.
`default_nettype none
`include "modbus_rtu_response_checker_macros.svh"
module modbus_rtu_response_checker (
	input wire logic clk,
	input wire logic arst_n,
	mrrc_req_if.sink   req,
	mrrc_rsp_if.source rsp
);
	import mrrc_pkg::*;

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] addr_s1;
	logic [7:0] byte_s1;

	phase_t      phase_q;
	logic [7:0]  target_q;
	logic [8:0]  position_q;
	logic [8:0]  total_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_low_q;
	logic [7:0]  func_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [8:0] out_pos_q;
	logic       out_last_q;
	logic [2:0] out_status_q;
	logic [7:0] out_exc_q;
	logic [7:0] out_func_q;

	logic [15:0] crc_next;
	logic        has_res;
	logic        adv;
	logic [7:0]  r_byte;
	logic        r_last;
	logic [2:0]  r_status;
	logic [7:0]  r_exc;
	logic [7:0]  r_func;
	phase_t      phase_d;
	logic [7:0]  target_d;
	logic [8:0]  position_d;
	logic [8:0]  total_d;
	logic [15:0] crc_d;
	logic [7:0]  crc_low_d;
	logic [7:0]  func_d;
	logic [9:0]  pos_plus2;
	logic [15:0] crc_got;

	mrrc_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (byte_s1),
		.crc_out (crc_next)
	);

	assign pos_plus2 = {1'b0, position_q} + 10'd2;
	assign crc_got   = {byte_s1, crc_low_q};

	always_comb begin
		has_res    = 1'b0;
		r_byte     = byte_s1;
		r_last     = 1'b0;
		r_status   = ST_OK;
		r_exc      = 8'h00;
		phase_d    = phase_q;
		target_d   = target_q;
		position_d = position_q;
		total_d    = total_q;
		crc_d      = crc_q;
		crc_low_d  = crc_low_q;
		func_d     = func_q;
		if (kind_s1 == KIND_ARM) begin
			phase_d    = PH_ADDR;
			target_d   = addr_s1;
			position_d = 9'd0;
			total_d    = 9'd0;
			crc_d      = CRC_INIT;
			crc_low_d  = 8'h00;
			func_d     = 8'h00;
		end else if (phase_q != PH_IDLE && kind_s1 == KIND_TIMEOUT) begin
			has_res  = 1'b1;
			r_byte   = 8'h00;
			r_last   = 1'b1;
			r_status = ST_TIMEOUT;
			phase_d  = PH_IDLE;
		end else if (phase_q != PH_IDLE && kind_s1 == KIND_BYTE) begin
			has_res    = 1'b1;
			position_d = position_q + 9'd1;
			case (phase_q)
				PH_ADDR: begin
					if (byte_s1 != target_q) begin
						r_last   = 1'b1;
						r_status = ST_SLAVE;
						phase_d  = PH_IDLE;
					end else begin
						crc_d   = crc_next;
						phase_d = PH_FUNC;
					end
				end
				PH_FUNC: begin
					func_d = byte_s1;
					crc_d  = crc_next;
					if (byte_s1[7]) begin
						phase_d = PH_EXC;
					end else begin
						case (byte_s1) inside
							[8'd1:8'd4]: begin
								phase_d = PH_COUNT;
							end
							FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: begin
								total_d = WRITE_FRAME_LEN;
								phase_d = PH_BODY;
							end
							default: begin
								r_last   = 1'b1;
								r_status = ST_FUNC;
								phase_d  = PH_IDLE;
							end
						endcase
					end
				end
				PH_EXC: begin
					r_last   = 1'b1;
					r_status = ST_EXCEPTION;
					r_exc    = byte_s1;
					phase_d  = PH_IDLE;
				end
				PH_COUNT: begin
					crc_d   = crc_next;
					total_d = READ_FRAME_BASE + {1'b0, byte_s1};
					phase_d = PH_BODY;
				end
				PH_BODY: begin
					if (pos_plus2 < {1'b0, total_q}) begin
						crc_d = crc_next;
					end else if (pos_plus2 == {1'b0, total_q}) begin
						crc_low_d = byte_s1;
					end else begin
						r_last   = 1'b1;
						r_status = (crc_got == crc_q) ? ST_OK : ST_CRC;
						phase_d  = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		r_func = func_d;
	end

	assign adv       = valid_s1 && (!has_res || !out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1 <= req.kind;
			addr_s1 <= req.slave_address;
			byte_s1 <= req.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			target_q   <= 8'h00;
			position_q <= 9'd0;
			total_q    <= 9'd0;
			crc_q      <= CRC_INIT;
			crc_low_q  <= 8'h00;
			func_q     <= 8'h00;
		end else if (adv) begin
			phase_q    <= phase_d;
			target_q   <= target_d;
			position_q <= position_d;
			total_q    <= total_d;
			crc_q      <= crc_d;
			crc_low_q  <= crc_low_d;
			func_q     <= func_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && has_res) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			out_byte_q   <= r_byte;
			out_pos_q    <= position_q;
			out_last_q   <= r_last;
			out_status_q <= r_status;
			out_exc_q    <= r_exc;
			out_func_q   <= r_func;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.frame_byte     = out_byte_q;
	assign rsp.byte_position  = out_pos_q;
	assign rsp.last           = out_last_q;
	assign rsp.status         = out_status_q;
	assign rsp.exception_code = out_exc_q;
	assign rsp.function_code  = out_func_q;

	`MRRC_ASSERT_NEXT(a_last_disarms, adv && has_res && r_last, phase_q == PH_IDLE)
	`MRRC_ASSERT_NEXT(a_arm_clears, adv && kind_s1 == KIND_ARM,
		position_q == 9'd0 && crc_q == CRC_INIT && phase_q == PH_ADDR)
	`MRRC_ASSERT_IMPL(a_mid_frame_ok, rsp.valid && !rsp.last,
		rsp.status == ST_OK && rsp.exception_code == 8'h00)
	`MRRC_ASSERT_IMPL(a_stall_blocks, valid_s1 && !adv, !req.ready)
endmodule
`default_nettype wire

// ===== tb/sv/mrrc_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
package mrrc_scoreboard_pkg;
	import mrrc_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [7:0] EXCEPTION_FLAG   = 8'h80;
	localparam logic [7:0] FC_READ_COILS    = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
	localparam logic [7:0] FC_READ_INPUT    = 8'd4;

	typedef logic [7:0] byte_queue_t[$];

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [8:0] byte_position;
		logic       last;
		logic [2:0] status;
		logic [7:0] exception_code;
		logic [7:0] function_code;
	} frame_result_t;

	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] value);
		logic [15:0] acc;
		acc = crc ^ {8'h00, value};
		for (int i = 0; i < 8; i++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		return acc;
	endfunction

	class response_scoreboard;
		phase_t        frame_phase;
		logic [7:0]    target;
		logic [8:0]    position;
		logic [8:0]    frame_total;
		logic [15:0]   crc;
		logic [7:0]    crc_low;
		logic [7:0]    function_seen;
		frame_result_t expected_q[$];
		int unsigned   mismatches;

		function new();
			frame_phase = PH_IDLE;
			target = 8'h00;
			position = 9'd0;
			frame_total = 9'd0;
			crc = CRC_INIT;
			crc_low = 8'h00;
			function_seen = 8'h00;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push(logic [7:0] value, logic [8:0] pos, logic last, logic [2:0] status,
				logic [7:0] exc);
			frame_result_t res;
			res.frame_byte = value;
			res.byte_position = pos;
			res.last = last;
			res.status = status;
			res.exception_code = exc;
			res.function_code = function_seen;
			expected_q = {expected_q, res};
		endfunction

		function void note_request(logic [1:0] kind, logic [7:0] addr, logic [7:0] value);
			logic [8:0] pos;
			pos = position;
			if (kind == KIND_ARM) begin
				frame_phase = PH_ADDR;
				target = addr;
				position = 9'd0;
				frame_total = 9'd0;
				crc = CRC_INIT;
				crc_low = 8'h00;
				function_seen = 8'h00;
				return;
			end
			if (frame_phase == PH_IDLE || kind == KIND_UNUSED) begin
				return;
			end
			if (kind == KIND_TIMEOUT) begin
				push(8'h00, pos, 1'b1, ST_TIMEOUT, 8'h00);
				frame_phase = PH_IDLE;
				return;
			end
			position = position + 9'd1;
			case (frame_phase)
				PH_ADDR: begin
					if (value != target) begin
						push(value, pos, 1'b1, ST_SLAVE, 8'h00);
						frame_phase = PH_IDLE;
						return;
					end
					crc = crc16_next(crc, value);
					frame_phase = PH_FUNC;
				end
				PH_FUNC: begin
					function_seen = value;
					crc = crc16_next(crc, value);
					if ((value & EXCEPTION_FLAG) != 8'h00) begin
						frame_phase = PH_EXC;
					end else if (value >= FC_READ_COILS && value <= FC_READ_INPUT) begin
						frame_phase = PH_COUNT;
					end else if (value == FC_WRITE_COIL || value == FC_WRITE_REG ||
							value == FC_WRITE_COILS || value == FC_WRITE_REGS) begin
						frame_total = WRITE_FRAME_LEN;
						frame_phase = PH_BODY;
					end else begin
						push(value, pos, 1'b1, ST_FUNC, 8'h00);
						frame_phase = PH_IDLE;
						return;
					end
				end
				PH_EXC: begin
					push(value, pos, 1'b1, ST_EXCEPTION, value);
					frame_phase = PH_IDLE;
					return;
				end
				PH_COUNT: begin
					crc = crc16_next(crc, value);
					frame_total = READ_FRAME_BASE + {1'b0, value};
					frame_phase = PH_BODY;
				end
				default: begin
					if (int'(pos) + 2 < int'(frame_total)) begin
						crc = crc16_next(crc, value);
					end else if (int'(pos) + 2 == int'(frame_total)) begin
						crc_low = value;
					end else begin
						push(value, pos, 1'b1, ({value, crc_low} == crc) ? ST_OK : ST_CRC, 8'h00);
						frame_phase = PH_IDLE;
						return;
					end
				end
			endcase
			push(value, pos, 1'b0, ST_OK, 8'h00);
		endfunction

		function void compare(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual byte %0h position %0d",
					$time, got.frame_byte, got.byte_position);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			compare("frame_byte", want.frame_byte, got.frame_byte);
			compare("byte_position", want.byte_position, got.byte_position);
			compare("last", want.last, got.last);
			compare("status", want.status, got.status);
			compare("exception_code", want.exception_code, got.exception_code);
			compare("function_code", want.function_code, got.function_code);
		endfunction
	endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import mrrc_pkg::*;
	import mrrc_scoreboard_pkg::*;

	logic clk;
	logic arst_n;
	bit steady;
	bit big_read_done;
	int unsigned sent;
	response_scoreboard board;

	mrrc_req_if req ();
	mrrc_rsp_if rsp ();

	modbus_rtu_response_checker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(negedge clk) begin
		rsp.ready <= steady || ($urandom_range(99) >= 18);
	end

	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			got.frame_byte = rsp.frame_byte;
			got.byte_position = rsp.byte_position;
			got.last = rsp.last;
			got.status = rsp.status;
			got.exception_code = rsp.exception_code;
			got.function_code = rsp.function_code;
			board.check_result(got);
		end
	end

	task automatic send_request(input logic [1:0] kind, input logic [7:0] addr,
			input logic [7:0] value);
		while (!steady && $urandom_range(99) < 18) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.slave_address <= addr;
		req.rx_byte <= value;
		do @(posedge clk); while (req.ready !== 1'b1);
		board.note_request(kind, addr, value);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_response(input logic [7:0] addr, input byte_queue_t frame);
		send_request(KIND_ARM, addr, 8'($urandom));
		foreach (frame[i]) begin
			send_request(KIND_BYTE, 8'($urandom), frame[i]);
		end
	endtask

	function automatic void append_crc(ref byte_queue_t frame);
		logic [15:0] crc;
		crc = CRC_INIT;
		foreach (frame[i]) begin
			crc = crc16_next(crc, frame[i]);
		end
		frame = {frame, crc[7:0], crc[15:8]};
	endfunction

	function automatic byte_queue_t good_response(input logic [7:0] addr);
		byte_queue_t frame;
		logic [7:0] fc;
		int unsigned count;
		case ($urandom_range(7))
			0: fc = FC_READ_COILS;
			1: fc = FC_READ_DISCRETE;
			2: fc = FC_READ_HOLDING;
			3: fc = FC_READ_INPUT;
			4: fc = FC_WRITE_COIL;
			5: fc = FC_WRITE_REG;
			6: fc = FC_WRITE_COILS;
			default: fc = FC_WRITE_REGS;
		endcase
		frame = {frame, addr, fc};
		if (fc <= FC_READ_INPUT) begin
			if (!big_read_done || $urandom_range(9) == 0) begin
				count = big_read_done ? $urandom_range(255, 128) : 255;
				big_read_done = 1'b1;
			end else begin
				count = $urandom_range(12);
			end
			frame = {frame, 8'(count)};
			repeat (count) frame = {frame, 8'($urandom)};
		end else begin
			repeat (4) frame = {frame, 8'($urandom)};
		end
		append_crc(frame);
		return frame;
	endfunction

	task automatic random_exchange();
		logic [7:0] addr;
		logic [7:0] fc;
		byte_queue_t frame;
		int unsigned pick;
		int unsigned spot;
		addr = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 55) begin
			frame = good_response(addr);
			if ($urandom_range(7) == 0) begin
				spot = $urandom_range(frame.size() - 1, 2);
				frame[spot] = frame[spot] ^ 8'(1 << $urandom_range(7));
			end
			send_response(addr, frame);
			if ($urandom_range(9) == 0) begin
				send_request(KIND_BYTE, 8'($urandom), 8'($urandom));
			end
		end else if (pick < 67) begin
			frame = {frame, addr, EXCEPTION_FLAG | 8'($urandom_range(127)), 8'($urandom)};
			send_response(addr, frame);
		end else if (pick < 74) begin
			frame = {frame, addr ^ 8'($urandom_range(255, 1))};
			send_response(addr, frame);
		end else if (pick < 80) begin
			do begin
				fc = 8'($urandom_range(127));
			end while ((fc >= FC_READ_COILS && fc <= FC_READ_INPUT) || fc == FC_WRITE_COIL ||
				fc == FC_WRITE_REG || fc == FC_WRITE_COILS || fc == FC_WRITE_REGS);
			frame = {frame, addr, fc};
			send_response(addr, frame);
		end else if (pick < 92) begin
			frame = good_response(addr);
			spot = $urandom_range(frame.size() - 1);
			while (frame.size() > spot) void'(frame.pop_back());
			send_response(addr, frame);
			if ($urandom_range(2) != 0) begin
				send_request(KIND_TIMEOUT, 8'($urandom), 8'($urandom));
			end
		end else begin
			repeat ($urandom_range(8, 1)) begin
				send_request(2'($urandom_range(3)), 8'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		byte_queue_t frame;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = KIND_ARM;
		req.slave_address = 8'h00;
		req.rx_byte = 8'h00;
		sent = 0;
		board = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A timeout while idle is dropped, a wrong address ends the frame, and a byte after it is dropped.
		send_request(KIND_TIMEOUT, 8'h00, 8'h00);
		send_request(KIND_ARM, 8'h11, 8'h00);
		send_request(KIND_BYTE, 8'h00, 8'h12);
		send_request(KIND_BYTE, 8'hFF, 8'h11);

		// The second arm drops the first frame after its address byte, and the new frame ends in an exception reply.
		send_request(KIND_ARM, 8'h42, 8'hFF);
		send_request(KIND_BYTE, 8'h00, 8'h42);
		frame = {frame, 8'hFF, 8'h83, 8'h02};
		send_response(8'hFF, frame);

		frame.delete();
		frame = {frame, 8'h00, 8'h07};
		send_response(8'h00, frame);

		frame.delete();
		frame = {frame, 8'h01, FC_READ_HOLDING, 8'h00};
		append_crc(frame);
		frame[4] = frame[4] ^ 8'h01;
		send_response(8'h01, frame);

		frame.delete();
		frame = {frame, 8'hF7, FC_WRITE_REGS, 8'h00, 8'h01, 8'hFF, 8'h02};
		append_crc(frame);
		send_response(8'hF7, frame);

		send_request(KIND_ARM, 8'h2C, 8'h00);
		send_request(KIND_BYTE, 8'h00, 8'h2C);
		send_request(KIND_UNUSED, 8'hFF, 8'hFF);
		send_request(KIND_TIMEOUT, 8'h00, 8'h00);

		while (sent < 1150) begin
			steady <= (sent >= 500 && sent < 700);
			random_exchange();
		end
		steady <= 1'b0;
		req.valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/mrrc_pkg.sv
sv/mrrc_req_if.sv
sv/mrrc_rsp_if.sv
sv/mrrc_crc_byte.sv
sv/modbus_rtu_response_checker.sv
tb/sv/mrrc_scoreboard_pkg.sv
tb/sv/testbench.sv
